### hw/rtl/tccs_pkg.sv
// types, codes and constants shared by the text console blocks
// no dependencies
`default_nettype none

package tccs_pkg;

  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int IDX_W   = 11;
  localparam int CFG_W   = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0]  CH_SPACE     = 8'd32;
  localparam logic [COLOR_W-1:0] RESET_FG     = 4'd15;
  localparam logic [COLOR_W-1:0] RESET_BG     = 4'd0;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BG = 1'b1;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
  } cell_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic rd_capture;
    logic put_exec;
    logic out_read;
    logic sweep_clr;
    logic sweep_inc;
    logic copy_rd;
    logic blank_wr;
    logic out_scroll;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic put_ovf;
    logic copy_last;
    logic sweep_end;
  } dp_sts_t;

endpackage

`default_nettype wire

### hw/rtl/tccs_ctrl.sv
// controller state machine: clear pass, command dispatch, scroll sequencing
// depends on tccs_pkg
`default_nettype none

module tccs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              in_operation,
  input  wire tccs_pkg::dp_sts_t sts,
  output tccs_pkg::dp_cmd_t      cmd,
  output logic                   busy
);

  tccs_pkg::state_t state_r;
  tccs_pkg::state_t state_nxt;
  logic             accept;

  assign accept = start && (state_r == tccs_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tccs_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tccs_pkg::ST_CLEAR: begin
        if (sts.sweep_end) state_nxt = tccs_pkg::ST_IDLE;
      end
      tccs_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_operation == tccs_pkg::OP_READ) begin
            state_nxt = tccs_pkg::ST_READ;
          end else if (sts.put_ovf) begin
            state_nxt = tccs_pkg::ST_COPY;
          end
        end
      end
      tccs_pkg::ST_READ:  state_nxt = tccs_pkg::ST_IDLE;
      tccs_pkg::ST_COPY: begin
        if (sts.copy_last) state_nxt = tccs_pkg::ST_DRAIN;
      end
      tccs_pkg::ST_DRAIN: state_nxt = tccs_pkg::ST_BLANK;
      tccs_pkg::ST_BLANK: begin
        if (sts.sweep_end) state_nxt = tccs_pkg::ST_IDLE;
      end
      default: state_nxt = tccs_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      tccs_pkg::ST_CLEAR: begin
        cmd.clear_wr  = 1'b1;
        cmd.sweep_inc = 1'b1;
      end
      tccs_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          if (in_operation == tccs_pkg::OP_READ) begin
            cmd.rd_capture = 1'b1;
          end else begin
            cmd.put_exec  = 1'b1;
            cmd.sweep_clr = 1'b1;
          end
        end
      end
      tccs_pkg::ST_READ: cmd.out_read = 1'b1;
      tccs_pkg::ST_COPY: begin
        cmd.copy_rd   = 1'b1;
        cmd.sweep_inc = 1'b1;
      end
      tccs_pkg::ST_DRAIN: begin
        // last copied cell is written back here
      end
      tccs_pkg::ST_BLANK: begin
        cmd.blank_wr   = 1'b1;
        cmd.sweep_inc  = 1'b1;
        cmd.out_scroll = sts.sweep_end;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_capture |=> (state_r == tccs_pkg::ST_READ))
    else $error("read transaction did not move to read state");
  a_ovf_scrolls: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.put_exec && sts.put_ovf) |=> (state_r == tccs_pkg::ST_COPY))
    else $error("overflowing put did not start a scroll");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.clear_wr, cmd.put_exec, cmd.blank_wr, cmd.copy_rd}) <= 1)
    else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

### hw/rtl/tccs_dp.sv
// datapath: screen memory, cursor and column, sweep counter, config and result registers
// depends on tccs_pkg
`default_nettype none

module tccs_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire tccs_pkg::dp_cmd_t               cmd,
  output tccs_pkg::dp_sts_t                    sts,
  input  wire logic [tccs_pkg::CHAR_W-1:0]     in_char_code,
  input  wire logic [tccs_pkg::IDX_W-1:0]      in_cell_index,
  input  wire logic                            cfg_we,
  input  wire logic [tccs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tccs_pkg::CFG_W-1:0]      cfg_wdata,
  output logic                                 out_valid,
  output logic [tccs_pkg::IDX_W-1:0]           out_cursor_pos,
  output logic [tccs_pkg::CHAR_W-1:0]          out_read_char,
  output logic [tccs_pkg::COLOR_W-1:0]         out_read_fg,
  output logic [tccs_pkg::COLOR_W-1:0]         out_read_bg,
  output logic                                 out_scrolled
);

  localparam int Cells  = ROWS * COLUMNS;
  localparam int Upper  = (ROWS - 1) * COLUMNS;
  localparam int AddrW  = $clog2(Cells);
  localparam int CurW   = $clog2(Cells + 1);
  localparam int ColW   = $clog2(COLUMNS);
  localparam int IdxW   = tccs_pkg::IDX_W;
  localparam int ColorW = tccs_pkg::COLOR_W;

  tccs_pkg::cell_t mem [Cells];
  tccs_pkg::cell_t rdata_r;
  logic [AddrW-1:0] rd_addr;

  logic             we;
  logic [AddrW-1:0] waddr;
  tccs_pkg::cell_t  wdata;

  logic [ColorW-1:0] fg_r;
  logic [ColorW-1:0] bg_r;

  logic [CurW-1:0]  cursor_r, cursor_nxt;
  logic [ColW-1:0]  col_r, col_nxt;
  logic [CurW-1:0]  put_cur;
  logic             put_ovf;
  logic             put_wr;
  logic             put_blank;

  logic [AddrW-1:0] sweep_r;
  logic             wb_en_r;
  logic [AddrW-1:0] wb_addr_r;
  logic             oob_r;

  logic [CurW-1:0]   out_cursor_r;
  logic [tccs_pkg::CHAR_W-1:0] out_char_r;
  logic [ColorW-1:0] out_fg_r;
  logic [ColorW-1:0] out_bg_r;
  logic              out_scrolled_r;
  logic              out_valid_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= tccs_pkg::RESET_FG;
      bg_r <= tccs_pkg::RESET_BG;
    end else if (cfg_we) begin
      case (cfg_index)
        tccs_pkg::REG_FG: fg_r <= cfg_wdata;
        tccs_pkg::REG_BG: bg_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // cursor update for a put
  always_comb begin
    put_cur   = cursor_r;
    col_nxt   = col_r;
    put_wr    = 1'b0;
    put_blank = 1'b0;
    case (in_char_code)
      tccs_pkg::CH_NEWLINE: begin
        put_cur = cursor_r + CurW'(COLUMNS) - CurW'(col_r);
        col_nxt = '0;
      end
      tccs_pkg::CH_BACKSPACE: begin
        if (cursor_r != '0) begin
          put_cur   = cursor_r - CurW'(1);
          col_nxt   = (col_r == '0) ? ColW'(COLUMNS - 1) : col_r - ColW'(1);
          put_blank = 1'b1;
        end
      end
      default: begin
        put_cur = cursor_r + CurW'(1);
        col_nxt = (col_r == ColW'(COLUMNS - 1)) ? '0 : col_r + ColW'(1);
        put_wr  = 1'b1;
      end
    endcase
    put_ovf    = (put_cur >= CurW'(Cells));
    // the scroll moves every row up, so the cursor goes up one row in the same column
    cursor_nxt = put_ovf ? put_cur - CurW'(COLUMNS) : put_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      col_r    <= '0;
    end else if (cmd.put_exec) begin
      cursor_r <= cursor_nxt;
      col_r    <= col_nxt;
    end
  end

  // sweep counter shared by clear, copy and blank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.sweep_clr) begin
      sweep_r <= '0;
    end else if (cmd.sweep_inc) begin
      sweep_r <= sweep_r + AddrW'(1);
    end
  end

  assign sts.put_ovf   = put_ovf;
  assign sts.copy_last = (sweep_r == AddrW'(Upper - 1));
  assign sts.sweep_end = (sweep_r == AddrW'(Cells - 1));

  // copy writeback is registered from the read and follows it in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_en_r <= 1'b0;
    end else begin
      wb_en_r <= cmd.copy_rd;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r <= sweep_r;
    if (cmd.rd_capture) begin
      oob_r <= (32'(in_cell_index) >= 32'(Cells));
    end
  end

  assign rd_addr = cmd.copy_rd ? AddrW'(sweep_r + AddrW'(COLUMNS)) : AddrW'(in_cell_index);

  always_comb begin
    we    = 1'b0;
    waddr = sweep_r;
    wdata = rdata_r;
    if (cmd.clear_wr) begin
      we    = 1'b1;
      wdata = '{ch: tccs_pkg::CH_SPACE, fg: tccs_pkg::RESET_FG, bg: tccs_pkg::RESET_BG};
    end else if (cmd.blank_wr) begin
      we    = 1'b1;
      wdata = '{ch: tccs_pkg::CH_SPACE, fg: fg_r, bg: bg_r};
    end else if (wb_en_r) begin
      we    = 1'b1;
      waddr = wb_addr_r;
    end else if (cmd.put_exec && put_wr) begin
      we    = 1'b1;
      waddr = AddrW'(cursor_r);
      wdata = '{ch: in_char_code, fg: fg_r, bg: bg_r};
    end else if (cmd.put_exec && put_blank) begin
      we    = 1'b1;
      waddr = AddrW'(put_cur);
      wdata = '{ch: tccs_pkg::CH_SPACE, fg: fg_r, bg: bg_r};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.put_exec && !put_ovf) || cmd.out_read || cmd.out_scroll;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_exec && !put_ovf) begin
      out_cursor_r   <= cursor_nxt;
      out_char_r     <= '0;
      out_fg_r       <= '0;
      out_bg_r       <= '0;
      out_scrolled_r <= 1'b0;
    end else if (cmd.out_read) begin
      out_cursor_r   <= cursor_r;
      out_char_r     <= oob_r ? '0 : rdata_r.ch;
      out_fg_r       <= oob_r ? '0 : rdata_r.fg;
      out_bg_r       <= oob_r ? '0 : rdata_r.bg;
      out_scrolled_r <= 1'b0;
    end else if (cmd.out_scroll) begin
      out_cursor_r   <= cursor_r;
      out_char_r     <= '0;
      out_fg_r       <= '0;
      out_bg_r       <= '0;
      out_scrolled_r <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_pos = IdxW'(out_cursor_r);
  assign out_read_char  = out_char_r;
  assign out_read_fg    = out_fg_r;
  assign out_read_bg    = out_bg_r;
  assign out_scrolled   = out_scrolled_r;

`ifndef ASSERT_OFF
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r < CurW'(Cells))
    else $error("cursor beyond the screen");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < 32'(COLUMNS))
    else $error("column beyond the row");
  a_wb_alone: assert property (@(posedge clk) disable iff (!rst_n)
    wb_en_r |-> !(cmd.put_exec || cmd.blank_wr || cmd.clear_wr))
    else $error("copy writeback collides with another write");
  a_cursor_held: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.put_exec |=> $stable(cursor_r))
    else $error("cursor moved without a put");
`endif

endmodule

`default_nettype wire

### hw/rtl/text_console_cursor_scroll_top.sv
// top level of the text console engine: controller plus datapath
// depends on tccs_pkg, tccs_ctrl, tccs_dp
`default_nettype none

// Text console over a ROWS x COLUMNS screen memory. After reset the block
// holds busy high while it fills every cell with a space in the reset
// colors. A transaction is taken when start is high and busy is low. A put
// without scroll leaves the block idle, so it can take the next transaction
// in the following cycle; a read passes through the registered read of the
// screen memory and then the read state. A put that runs past the last
// cell scrolls: the single memory write port copies one cell a cycle, so the
// scroll moves the upper rows up one row and then blanks the bottom row.
// Every transaction yields one result, shown for a single cycle with
// out_valid; the receiver has no way to stall it.
module text_console_cursor_scroll_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic                                  in_operation,
  input  wire logic [tccs_pkg::CHAR_W-1:0]           in_char_code,
  input  wire logic [tccs_pkg::IDX_W-1:0]            in_cell_index,
  output logic                                       out_valid,
  output logic [tccs_pkg::IDX_W-1:0]                 out_cursor_pos,
  output logic [tccs_pkg::CHAR_W-1:0]                out_read_char,
  output logic [tccs_pkg::COLOR_W-1:0]               out_read_fg,
  output logic [tccs_pkg::COLOR_W-1:0]               out_read_bg,
  output logic                                       out_scrolled,
  input  wire logic                                  cfg_we,
  input  wire logic [tccs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [tccs_pkg::CFG_W-1:0]            cfg_wdata
);

  tccs_pkg::dp_cmd_t cmd;
  tccs_pkg::dp_sts_t sts;

  tccs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy)
  );

  tccs_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_char_code   (in_char_code),
    .in_cell_index  (in_cell_index),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_cursor_pos (out_cursor_pos),
    .out_read_char  (out_read_char),
    .out_read_fg    (out_read_fg),
    .out_read_bg    (out_read_bg),
    .out_scrolled   (out_scrolled)
  );

endmodule

`default_nettype wire
